// File: src/herp_pkg.sv
// Shared types and constants for the heading error to rudder pulse block.
`default_nettype none
package herp_pkg;

  localparam int ANGLE_W = 32;
  localparam int CW = 36;
  localparam int ATAN_TABLE_SIZE = 24;
  localparam int PULSE_W = 11;
  localparam int SPAN_W = 10;
  localparam int PROD_W = ANGLE_W + SPAN_W;

  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;
  localparam logic [SPAN_W-1:0] PULSE_SPAN = 10'd1000;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_TABLE_SIZE] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                    valid;
    logic                    zero;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic [ANGLE_W-1:0]      z;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] angle;
  } lane_out_t;

endpackage
`default_nettype wire

// File: src/herp_cordic_stage.sv
// One registered CORDIC vectoring iteration.
`default_nettype none
module herp_cordic_stage
  import herp_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cordic_t d,
  output cordic_t      q
);

  logic                 valid;
  logic                 zero;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic [ANGLE_W-1:0]   z;

  logic signed [CW-1:0] x_next;
  logic signed [CW-1:0] y_next;
  logic [ANGLE_W-1:0]   z_next;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  always_comb begin
    xs = d.x >>> SHIFT;
    ys = d.y >>> SHIFT;
    if (d.y > 0) begin
      x_next = d.x + ys;
      y_next = d.y - xs;
      z_next = d.z + ATAN_TURNS[SHIFT];
    end else begin
      x_next = d.x - ys;
      y_next = d.y + xs;
      z_next = d.z - ATAN_TURNS[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    zero <= d.zero;
    x    <= x_next;
    y    <= y_next;
    z    <= z_next;
  end

  assign q = '{valid: valid, zero: zero, x: x, y: y, z: z};

endmodule
`default_nettype wire

// File: src/herp_lane.sv
// One CORDIC atan2 lane: half-plane fold and scaling, then the iteration pipeline.
`default_nettype none
module herp_lane
  import herp_pkg::*;
#(
  parameter int ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [15:0] vx,
  input  wire logic [15:0] vy,
  output lane_out_t        out
);

  logic                 valid;
  logic                 zero;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic [ANGLE_W-1:0]   z;

  logic                 neg;
  logic signed [16:0]   xe;
  logic signed [16:0]   ye;
  logic signed [16:0]   xn;
  logic signed [16:0]   yn;

  cordic_t chain [ITERATIONS+1];

  always_comb begin
    xe  = {vx[15], vx};
    ye  = {vy[15], vy};
    neg = vx[15];
    xn  = neg ? -xe : xe;
    yn  = neg ? -ye : ye;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // scale by 2^16 after folding the left half plane onto the right
  always_ff @(posedge clk) begin
    zero <= (vx == 16'd0) && (vy == 16'd0);
    x    <= {{(CW-33){xn[16]}}, xn, 16'd0};
    y    <= {{(CW-33){yn[16]}}, yn, 16'd0};
    z    <= neg ? HALF_TURN : '0;
  end

  assign chain[0] = '{valid: valid, zero: zero, x: x, y: y, z: z};

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    herp_cordic_stage #(
      .SHIFT(i)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .d  (chain[i]),
      .q  (chain[i+1])
    );
  end

  assign out.valid = chain[ITERATIONS].valid;
  assign out.angle = chain[ITERATIONS].zero ? '0 : chain[ITERATIONS].z;

endmodule
`default_nettype wire

// File: src/herp_merge.sv
// Angle difference, wrap, linear map to servo pulse and clamp.
`default_nettype none
module herp_merge
  import herp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lane_out_t  boat,
  input  wire lane_out_t  target,
  output logic            done,
  output logic [PULSE_W-1:0] rudder_pulse,
  output logic            saturated
);

  logic                 valid1;
  logic [PROD_W-1:0]    prod;

  logic [ANGLE_W-1:0]   u;
  logic [PROD_W-1:0]    rounded;
  logic [PULSE_W:0]     pulse_raw;
  logic [PULSE_W-1:0]   pulse_next;
  logic                 sat_next;

  // wrapped difference offset by half a turn: flipping the MSB adds 2^31
  assign u = (target.angle - boat.angle) ^ HALF_TURN;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= boat.valid & target.valid;
      done   <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(u) * PROD_W'(PULSE_SPAN);
  end

  always_comb begin
    rounded   = prod + PROD_W'(HALF_TURN);
    pulse_raw = (PULSE_W+1)'(PULSE_MIN) + (PULSE_W+1)'(rounded[PROD_W-1:ANGLE_W]);
    priority if (pulse_raw > (PULSE_W+1)'(PULSE_MAX)) begin
      pulse_next = PULSE_MAX;
      sat_next   = 1'b1;
    end else if (pulse_raw < (PULSE_W+1)'(PULSE_MIN)) begin
      pulse_next = PULSE_MIN;
      sat_next   = 1'b1;
    end else begin
      pulse_next = pulse_raw[PULSE_W-1:0];
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rudder_pulse <= pulse_next;
    saturated    <= sat_next;
  end

endmodule
`default_nettype wire

// File: src/heading_error_rudder_pulse_top.sv
// Path from the accepting edge to the done strobe: one fold/scale register,
// one register per CORDIC iteration, two in the merge.
// Throughput: one transaction per cycle; both vector lanes and the merge are fully
// pipelined, so busy is low except during reset.
// Reset: synchronous active-high rst clears all valid bits; no result is in flight after.
`default_nettype none
module heading_error_rudder_pulse_top
  import herp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] boat_x,
  input  wire logic signed [15:0] boat_y,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  output logic                    done,
  output logic [PULSE_W-1:0]      rudder_pulse,
  output logic                    saturated
);

  localparam int NITER = (CORDIC_ITERATIONS > ATAN_TABLE_SIZE) ?
                         ATAN_TABLE_SIZE : CORDIC_ITERATIONS;

  logic      accept;
  lane_out_t boat_lane;
  lane_out_t target_lane;

  assign busy   = rst;
  assign accept = start & ~busy;

  herp_lane #(
    .ITERATIONS(NITER)
  ) u_boat (
    .clk     (clk),
    .rst     (rst),
    .in_valid(accept),
    .vx      (boat_x),
    .vy      (boat_y),
    .out     (boat_lane)
  );

  herp_lane #(
    .ITERATIONS(NITER)
  ) u_target (
    .clk     (clk),
    .rst     (rst),
    .in_valid(accept),
    .vx      (target_x),
    .vy      (target_y),
    .out     (target_lane)
  );

  herp_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .boat        (boat_lane),
    .target      (target_lane),
    .done        (done),
    .rudder_pulse(rudder_pulse),
    .saturated   (saturated)
  );

endmodule
`default_nettype wire

// File: src/herp_checker.sv
// Port-level checks for heading_error_rudder_pulse_top, bound to the top level.
`default_nettype none
module herp_checker
  import herp_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic signed [15:0] boat_x,
  input wire logic signed [15:0] boat_y,
  input wire logic signed [15:0] target_x,
  input wire logic signed [15:0] target_y,
  input wire logic               done,
  input wire logic [PULSE_W-1:0] rudder_pulse,
  input wire logic               saturated
);

  localparam int NITER = (CORDIC_ITERATIONS > ATAN_TABLE_SIZE) ?
                         ATAN_TABLE_SIZE : CORDIC_ITERATIONS;
  localparam int LAT = NITER + 3;

  // every result traces back to an earlier accepted transaction
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a matching transaction");

  // identical headings give zero error, i.e. the center pulse
  a_same_heading_center: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && boat_x == target_x && boat_y == target_y)
      |-> ##LAT (done && rudder_pulse == PULSE_MIN + 11'd500))
    else $error("equal headings did not give center pulse");

  a_pulse_in_span: assert property (@(posedge clk) disable iff (rst)
    done |-> (rudder_pulse >= PULSE_MIN && rudder_pulse <= PULSE_MAX))
    else $error("rudder pulse out of span");

  // error is wrapped before mapping, so the clamp never engages
  a_no_saturation: assert property (@(posedge clk) disable iff (rst)
    done |-> !saturated)
    else $error("saturated set on wrapped error");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done after reset");

endmodule

bind heading_error_rudder_pulse_top herp_checker #(
  .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
) u_herp_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the heading error to rudder pulse block.
`timescale 1ns / 100ps

module testbench;
  import herp_pkg::*;

  localparam int ITERS = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int STALL_LIMIT = 2000;

  class rudder_scoreboard;
    typedef struct packed {
      logic [PULSE_W-1:0] pulse;
      logic               sat;
    } pulse_expect_t;

    pulse_expect_t pulse_q[$];
    int            iterations;
    int unsigned   mismatches;
    int unsigned   commands;
    int unsigned   checked;
    int unsigned   full_deflection;
    int unsigned   pulse_lo;
    int unsigned   pulse_hi;

    function new(int iters);
      iterations = iters;
      mismatches = 0;
      commands = 0;
      checked = 0;
      full_deflection = 0;
      pulse_lo = 4095;
      pulse_hi = 0;
    endfunction

    // vectoring CORDIC, binary angle out (2^32 per turn)
    function logic [ANGLE_W-1:0] heading_angle(logic signed [15:0] xin, logic signed [15:0] yin);
      longint             x;
      longint             y;
      longint             xs;
      longint             ys;
      logic [ANGLE_W-1:0] z;
      int                 n;
      x = longint'(xin);
      y = longint'(yin);
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_TURN;
      end
      x = x * 65536;
      y = y * 65536;
      n = (iterations > ATAN_TABLE_SIZE) ? ATAN_TABLE_SIZE : iterations;
      for (int i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end
      end
      return z;
    endfunction

    function void note_command(logic signed [15:0] bx, logic signed [15:0] by,
                               logic signed [15:0] tx, logic signed [15:0] ty);
      logic [ANGLE_W-1:0] err;
      logic [ANGLE_W-1:0] u;
      logic [63:0]        scaled;
      logic [63:0]        pulse;
      pulse_expect_t      e;
      err = heading_angle(tx, ty) - heading_angle(bx, by);
      u = err + HALF_TURN;
      scaled = ({32'b0, u} * 64'd1000 + 64'h8000_0000) >> 32;
      pulse = 64'd1000 + scaled;
      e.sat = 1'b0;
      if (pulse > 64'(PULSE_MAX)) begin
        pulse = 64'(PULSE_MAX);
        e.sat = 1'b1;
      end else if (pulse < 64'(PULSE_MIN)) begin
        pulse = 64'(PULSE_MIN);
        e.sat = 1'b1;
      end
      e.pulse = pulse[PULSE_W-1:0];
      pulse_q.push_back(e);
      commands++;
    endfunction

    function void check_result(logic [PULSE_W-1:0] pulse, logic sat);
      pulse_expect_t e;
      if (pulse_q.size() == 0) begin
        $error("unexpected result: rudder_pulse=%0d saturated=%0b", pulse, sat);
        mismatches++;
        return;
      end
      e = pulse_q.pop_front();
      checked++;
      if (pulse !== e.pulse) begin
        $error("rudder_pulse mismatch: expected %0d, actual %0d", e.pulse, pulse);
        mismatches++;
      end
      if (sat !== e.sat) begin
        $error("saturated mismatch: expected %0b, actual %0b", e.sat, sat);
        mismatches++;
      end
      if (32'(e.pulse) < pulse_lo) pulse_lo = 32'(e.pulse);
      if (32'(e.pulse) > pulse_hi) pulse_hi = 32'(e.pulse);
      if (e.pulse == PULSE_MIN || e.pulse == PULSE_MAX) full_deflection++;
    endfunction

    function int outstanding();
      return pulse_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] boat_x;
  logic signed [15:0] boat_y;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic               done;
  logic [PULSE_W-1:0] rudder_pulse;
  logic               saturated;

  rudder_scoreboard sb = new(ITERS);

  heading_error_rudder_pulse_top #(
    .CORDIC_ITERATIONS(ITERS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .boat_x(boat_x),
    .boat_y(boat_y),
    .target_x(target_x),
    .target_y(target_y),
    .done(done),
    .rudder_pulse(rudder_pulse),
    .saturated(saturated)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitor: values seen at the edge are the ones the block registers
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_command(boat_x, boat_y, target_x, target_y);
      if (done) sb.check_result(rudder_pulse, saturated);
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_heading(input logic signed [15:0] bx, input logic signed [15:0] by,
                              input logic signed [15:0] tx, input logic signed [15:0] ty);
    start = 1'b1;
    boat_x = bx;
    boat_y = by;
    target_x = tx;
    target_y = ty;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic pause_sender(input bit burst);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (burst || r < 50) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      start = 1'b0;
      boat_x = 16'($urandom);
      boat_y = 16'($urandom);
      target_x = 16'($urandom);
      target_y = 16'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] edge_component();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // watchdog on cycles without any transaction
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) stalled = 0;
      else stalled++;
    end
    $display("timeout: %0d cycles without a transaction", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    int unsigned        mix;
    bit                 burst;
    rst = 1'b1;
    start = 1'b0;
    boat_x = '0;
    boat_y = '0;
    target_x = '0;
    target_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero vectors, axes, left half plane, extremes, opposite headings
    send_heading(0, 0, 0, 0);                           pause_sender(0);
    send_heading(0, 0, 16384, 0);                       pause_sender(0);
    send_heading(0, 16384, 0, 0);                       pause_sender(0);
    send_heading(16384, 0, 16384, 0);                   pause_sender(0);
    send_heading(16384, 0, 0, 16384);                   pause_sender(0);
    send_heading(16384, 0, 0, -16384);                  pause_sender(0);
    send_heading(16384, 0, -16384, 0);                  pause_sender(0);
    send_heading(-16384, 0, 16384, 0);                  pause_sender(0);
    send_heading(-16384, 1, -16384, -1);                pause_sender(0);
    send_heading(-16384, -1, -16384, 1);                pause_sender(0);
    send_heading(0, -16384, 0, 16384);                  pause_sender(1);
    send_heading(-32768, -32768, 32767, 32767);         pause_sender(1);
    send_heading(32767, 32767, -32768, -32768);         pause_sender(1);
    send_heading(-32768, 0, 32767, 0);                  pause_sender(1);
    send_heading(0, -32768, 0, 32767);                  pause_sender(0);
    send_heading(32767, -32768, -32768, 32767);         pause_sender(0);
    send_heading(1, 0, -1, 0);                          pause_sender(0);
    send_heading(-1, -1, 1, 1);                         pause_sender(0);
    send_heading(16384, 1, -16384, 0);                  pause_sender(0);
    send_heading(16384, -1, -16384, 0);                 pause_sender(0);
    send_heading(11585, 11585, -11585, -11585);         pause_sender(0);
    send_heading(-1, 0, 0, -1);                         pause_sender(0);

    burst = 0;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 250 == 0) burst = ($urandom_range(0, 2) == 0);
      mix = $urandom_range(0, 9);
      bx = 16'($urandom);
      by = 16'($urandom);
      tx = 16'($urandom);
      ty = 16'($urandom);
      if (mix < 2) begin
        bx = 16'($urandom_range(0, 8) - 4);
        by = 16'($urandom_range(0, 8) - 4);
        tx = 16'($urandom_range(0, 8) - 4);
        ty = 16'($urandom_range(0, 8) - 4);
      end else if (mix < 4) begin
        // near-opposite headings push the error toward the wrap point
        tx = 16'(-bx + ($urandom_range(0, 6) - 3));
        ty = 16'(-by + ($urandom_range(0, 6) - 3));
      end else if (mix < 5) begin
        bx = edge_component();
        by = edge_component();
        tx = edge_component();
        ty = edge_component();
      end
      send_heading(bx, by, tx, ty);
      pause_sender(burst);
    end
    start = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (ITERS + 10) @(posedge clk);

    if (sb.outstanding() != 0) begin
      $error("%0d expected pulses never arrived", sb.outstanding());
      sb.mismatches++;
    end
    $display("Covered %0d commands, %0d pulses checked, range %0d..%0d us, %0d at full deflection",
             sb.commands, sb.checked, sb.pulse_lo, sb.pulse_hi, sb.full_deflection);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
